/* design/pmc_pkg.sv */
// pmc_pkg: shared types, codes and constants for the palette/material colorizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pmc_pkg;

    // Input item modes
    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_PAL_WR = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_MATERIAL_COLORS   = 3'd0;
    localparam logic [2:0] CFG_KEY_COLOR         = 3'd1;
    localparam logic [2:0] CFG_BASE_ALPHA        = 3'd2;
    localparam logic [2:0] CFG_MATERIAL_ALPHAS   = 3'd3;
    localparam logic [2:0] CFG_RUST_LEVELS       = 3'd4;
    localparam logic [2:0] CFG_ALLOW_REGULAR     = 3'd5;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    localparam logic [31:0] LCG_MUL       = 32'd1103515245;
    localparam logic [31:0] LCG_ADD       = 32'd12345;
    localparam logic [10:0] CH_MAX        = 11'h7FF;
    localparam logic [7:0]  MATERIAL_BASE = 8'd192;

    // Decoupling queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  pixel_index;
        logic [23:0] palette_rgb;
    } in_item_t;

    typedef struct packed {
        logic [15:0] color_out;
        logic [7:0]  alpha_out;
    } out_item_t;

    typedef struct packed {
        logic [63:0] material_colors;
        logic [15:0] key_color;
        logic [7:0]  base_alpha;
        logic [31:0] material_alphas;
        logic [31:0] rust_levels;
        logic        allow_regular;
    } cfg_t;

    // Classified pixel as it travels from front to back.
    // is_mat set: color is the material colour still to be shaded.
    // is_mat clear: color is final.
    typedef struct packed {
        logic        is_mat;
        logic [15:0] color;
        logic [3:0]  shade;
        logic        dim;
        logic [7:0]  alpha;
    } q_item_t;

endpackage

/* design/pmc_front.sv */
// pmc_front: input acceptance, palette memory, rust seeds and pixel classification.
// Depends on pmc_pkg; feeds pmc_fifo.
`timescale 1ns / 1ps

module pmc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  pmc_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  pmc_pkg::in_item_t in_data,
    output logic              push_valid,
    input  logic              push_ready,
    output pmc_pkg::q_item_t  push_item
);
    import pmc_pkg::*;

    logic [23:0] pal_mem [256];
    logic [23:0] pal_rd_reg;
    logic [31:0] seed_reg [4];
    logic [31:0] seed_next [4];

    logic        f_valid_reg, f_valid_next;
    q_item_t     f_item_reg, f_item_next;
    logic        f_regular_reg, f_regular_next;

    logic        accept, push;
    logic        pix_beat, wr_beat, start_beat;
    logic [7:0]  idx;
    logic        is_mat_idx;
    logic [1:0]  ci;
    logic [15:0] mat_c;
    logic [7:0]  rb;
    logic        mat_transp;
    logic        rust_on;
    logic [31:0] seed_new;
    logic        dim_hit;

    assign push     = f_valid_reg && push_ready;
    assign in_ready = !f_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    assign pix_beat   = accept && (in_data.mode == MODE_PIXEL);
    assign wr_beat    = accept && (in_data.mode == MODE_PAL_WR);
    assign start_beat = accept && (in_data.mode == MODE_START);

    assign idx        = in_data.pixel_index;
    assign is_mat_idx = idx >= MATERIAL_BASE;
    assign ci         = idx[5:4];
    assign mat_c      = cfg.material_colors[{ci, 4'b0000} +: 16];
    assign rb         = cfg.rust_levels[{ci, 3'b000} +: 8];
    assign mat_transp = mat_c == cfg.key_color;
    assign rust_on    = (cfg.rust_levels != 32'd0) && (rb != 8'd0);

    // One LCG step of the selected material's seed
    assign seed_new = 32'(seed_reg[ci] * LCG_MUL) + LCG_ADD;
    assign dim_hit  = rb[1:0] > seed_new[31:30];

    // Palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_beat)
        begin
            pal_mem[idx] <= in_data.palette_rgb;
        end
        if (pix_beat)
        begin
            pal_rd_reg <= pal_mem[idx];
        end
    end

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            seed_next[n] = seed_reg[n];
            if (start_beat)
            begin
                seed_next[n] = {26'd0, cfg.rust_levels[8 * n + 2 +: 6]};
            end
        end
        if (pix_beat && is_mat_idx && !mat_transp && rust_on)
        begin
            seed_next[ci] = seed_new;
        end
    end

    always_comb
    begin
        f_valid_next   = f_valid_reg;
        f_item_next    = f_item_reg;
        f_regular_next = f_regular_reg;
        if (push)
        begin
            f_valid_next = 1'b0;
        end
        if (pix_beat)
        begin
            f_valid_next         = 1'b1;
            f_regular_next       = 1'b0;
            f_item_next.is_mat   = 1'b0;
            f_item_next.color    = cfg.key_color;
            f_item_next.shade    = idx[3:0];
            f_item_next.dim      = 1'b0;
            f_item_next.alpha    = cfg.base_alpha;
            if (is_mat_idx)
            begin
                if (!mat_transp)
                begin
                    f_item_next.is_mat = 1'b1;
                    f_item_next.color  = mat_c;
                    f_item_next.dim    = rust_on && dim_hit;
                    f_item_next.alpha  = cfg.material_alphas[{ci, 3'b000} +: 8];
                end
            end
            else if (cfg.allow_regular)
            begin
                f_regular_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            for (int n = 0; n < 4; n++)
            begin
                seed_reg[n] <= 32'd0;
            end
        end
        else
        begin
            f_valid_reg <= f_valid_next;
            for (int n = 0; n < 4; n++)
            begin
                seed_reg[n] <= seed_next[n];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        f_item_reg    <= f_item_next;
        f_regular_reg <= f_regular_next;
    end

    // Palette entries become RGB565 on their way into the queue
    always_comb
    begin
        push_item = f_item_reg;
        if (f_regular_reg)
        begin
            push_item.color = {pal_rd_reg[23:19], pal_rd_reg[15:10], pal_rd_reg[7:3]};
        end
    end
    assign push_valid = f_valid_reg;

    a_pixel_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        pix_beat |=> f_valid_reg)
        else $error("pixel beat did not reach the classify stage");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg && !push_ready |=> f_valid_reg && $stable(f_item_reg))
        else $error("classify stage lost or changed a pixel while stalled");

endmodule

/* design/pmc_fifo.sv */
// pmc_fifo: short flop-based queue between the classify front and the shading back.
// Depends on pmc_pkg (q_item_t, QDEPTH).
`timescale 1ns / 1ps

module pmc_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  pmc_pkg::q_item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output pmc_pkg::q_item_t pop_item
);
    import pmc_pkg::*;

    q_item_t             entry_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
        else $error("queue pointers disagree with count");

endmodule

/* design/pmc_back.sv */
// pmc_back: shade multiply, rust dimming, saturation and RGB565 packing, output register.
// Depends on pmc_pkg; fed by pmc_fifo.
`timescale 1ns / 1ps

module pmc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  pmc_pkg::q_item_t  pop_item,
    output logic              out_valid,
    input  logic              out_ready,
    output pmc_pkg::out_item_t out_data
);
    import pmc_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      pop;

    logic [11:0] r_mul, g_mul, b_mul;
    logic [13:0] g_x3;
    logic [11:0] g_dim, b_dim;
    logic [10:0] r_sat, g_sat, b_sat;

    function automatic logic [10:0] sat_ch(input logic [11:0] v);
        sat_ch = v[11] ? CH_MAX : v[10:0];
    endfunction

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        r_mul = {4'b0000, pop_item.color[15:11], 3'b000} * {8'h00, pop_item.shade};
        g_mul = {4'b0000, pop_item.color[10:5], 2'b00} * {8'h00, pop_item.shade};
        b_mul = {4'b0000, pop_item.color[4:0], 3'b000} * {8'h00, pop_item.shade};
        g_x3  = {1'b0, g_mul, 1'b0} + {2'b00, g_mul};
        g_dim = pop_item.dim ? g_x3[13:2] : g_mul;
        b_dim = pop_item.dim ? {1'b0, b_mul[11:1]} : b_mul;
        r_sat = sat_ch(r_mul);
        g_sat = sat_ch(g_dim);
        b_sat = sat_ch(b_dim);

        out_data_next.alpha_out = pop_item.alpha;
        if (pop_item.is_mat)
        begin
            out_data_next.color_out = {r_sat[10:6], g_sat[10:5], b_sat[10:6]};
        end
        else
        begin
            out_data_next.color_out = pop_item.color;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/palette_material_colorizer_unit.sv */
// palette_material_colorizer_unit: top level with configuration registers.
// Depends on pmc_pkg, pmc_front, pmc_fifo and pmc_back.
`timescale 1ns / 1ps

// Usage
//   Input beats (in_valid/in_ready, in_data) carry a mode: a pixel index, a palette
//   entry write, or an image start that reloads the four rust seeds. Only pixel
//   beats produce an output beat (out_valid/out_ready, out_data: RGB565 + alpha).
//   Palette writes and image starts take effect at their accept edge, so a pixel
//   accepted right after sees them.
//   Path: an accepted pixel is registered in the classify stage, passes the queue
//   and is loaded into the output register, which presents it on out_data.
//   Throughput: one beat per clock while in_ready stays high. The rust LCG step of
//   one material is a single 32x32 multiply-add per cycle in the front, so
//   back-to-back pixels of the same material chain through it without a bubble.
//   Stalls: the output register and a 4-entry queue decouple the sides; when the
//   receiver holds out_ready low the queue fills, then the classify stage, and
//   only then does in_ready drop. Nothing is dropped or repeated.
//   Reset (rst_n low, asynchronous): all handshake state empties, rust seeds go to
//   zero and the configuration registers take their defaults. The palette memory
//   is not cleared; entries must be written before they are read.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr; the user must write
//   only while the block is idle (the block does not enforce it). Unknown indexes are ignored.

module palette_material_colorizer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  pmc_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pmc_pkg::out_item_t              out_data
);
    import pmc_pkg::*;

    cfg_t    cfg_reg, cfg_next;

    // front -> queue
    logic    fq_valid, fq_ready;
    q_item_t fq_item;
    // queue -> back
    logic    qb_valid, qb_ready;
    q_item_t qb_item;

    // Configuration register file, write-only
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MATERIAL_COLORS:   cfg_next.material_colors   = cfg_wdata;
                CFG_KEY_COLOR:         cfg_next.key_color         = cfg_wdata[15:0];
                CFG_BASE_ALPHA:        cfg_next.base_alpha        = cfg_wdata[7:0];
                CFG_MATERIAL_ALPHAS:   cfg_next.material_alphas   = cfg_wdata[31:0];
                CFG_RUST_LEVELS:       cfg_next.rust_levels       = cfg_wdata[31:0];
                CFG_ALLOW_REGULAR:     cfg_next.allow_regular     = cfg_wdata[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.material_colors   <= 64'd0;
            cfg_reg.key_color         <= 16'hF81F;
            cfg_reg.base_alpha        <= 8'hFF;
            cfg_reg.material_alphas   <= 32'hFFFF_FFFF;
            cfg_reg.rust_levels       <= 32'd0;
            cfg_reg.allow_regular     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accepts beats, owns palette and seeds, classifies pixels
    pmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item)
    );

    // Decoupling queue
    pmc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // Back: shading, saturation, packing and the output register
    pmc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
